// ===== sv/ssa_pkg.sv =====
// Shared types, constants and helper functions of the scaled sigmoid activation.
package ssa_pkg;

  localparam int unsigned WORD_W = 48;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned Q_W    = 32;
  localparam int unsigned TERMS  = 12;

  // ln 2 and ln 1e24 in Q.31, argument cap of 64.0 in Q.31
  localparam logic [30:0] LN2_Q31  = 31'd1488522236;
  localparam logic [37:0] TAIL_Q31 = 38'd118674332048;
  localparam logic [37:0] XCAP_Q31 = 38'd137438953472;
  // floor(2^63 / LN2_Q31): reciprocal for the range reduction
  localparam logic [32:0] INV_LN2  = 33'((64'd1 << 63) / 64'd1488522236);

  localparam logic [47:0] RECT_CAP = 48'd65536000000;
  localparam logic [47:0] ONE_Q16  = 48'd65536;
  localparam logic [47:0] HALF_Q16 = 48'd32768;
  localparam logic [47:0] POS_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_MAX  = 48'h8000_0000_0000;

  localparam logic [46:0] SPAN_B_RST  = 47'd65536;
  localparam logic [47:0] SLOPE_C_RST = 48'hFFFF_FFFC_0000;

  typedef enum logic [1:0] {
    CFG_RECT    = 2'd0,
    CFG_FLOOR_A = 2'd1,
    CFG_SPAN_B  = 2'd2,
    CFG_SLOPE_C = 2'd3
  } ssa_cfg_idx_e;

  typedef struct packed {
    logic        rect;
    logic [47:0] floor_a;
    logic [46:0] span_b;
    logic [47:0] slope_c;
  } ssa_cfg_t;

  // per-transaction control that rides along the pipeline
  typedef struct packed {
    logic        func;
    logic        xneg;
    logic        byp;
    logic        byp_clamp;
    logic [47:0] byp_res;
  } ssa_side_t;

  // one stage of the Taylor series
  typedef struct packed {
    ssa_side_t   side;
    logic [30:0] r;
    logic [6:0]  n;
    logic [31:0] sum;
    logic [31:0] term;
  } ssa_tay_t;

  function automatic logic [47:0] mag48(input logic [47:0] v);
    return v[47] ? 48'(-v) : v;
  endfunction

  // a + p, saturated to the signed word range (p is never negative)
  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [46:0] p);
    logic [49:0] s;
    s = {{2{a[47]}}, a} + {3'b000, p};
    if (!s[49] && (s[48] || s[47])) return POS_MAX;
    return s[47:0];
  endfunction

endpackage

// ===== sv/ssa_front.sv =====
// Front end: rectifier result, c*u product, tail test and ln2 range reduction.
module ssa_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  logic [47:0]          u_i,
  input  logic                 func_i,
  input  ssa_pkg::ssa_cfg_t    cfg_i,
  output logic                 valid_o,
  output ssa_pkg::ssa_side_t   side_o,
  output logic [30:0]          r_o,
  output logic [6:0]           n_o
);

  // stage A: magnitudes, operand narrowing, rectifier result
  logic [47:0] umag, cmag, rect_v, rect_d, rect_p;
  logic        uneg, c_mid, u_mid, cap, rect_hit;
  logic [18:0] op_n;
  logic [37:0] op_w;
  ssa_pkg::ssa_side_t side_a;

  always_comb begin
    umag   = ssa_pkg::mag48(u_i);
    cmag   = ssa_pkg::mag48(cfg_i.slope_c);
    uneg   = u_i[47];
    c_mid  = |cmag[47:19];
    u_mid  = |umag[47:19];
    cap    = ((|cmag[47:38]) && (umag != '0)) || ((|umag[47:38]) && (cmag != '0)) ||
             (c_mid && u_mid);
    op_n   = c_mid ? umag[18:0] : cmag[18:0];
    op_w   = c_mid ? cmag[37:0] : umag[37:0];
    rect_hit = !uneg && (umag >= ssa_pkg::RECT_CAP);
    rect_p = uneg ? '0 : (rect_hit ? ssa_pkg::RECT_CAP : umag);
    rect_v = ssa_pkg::sat_add(cfg_i.floor_a, rect_p[46:0]);
    rect_d = uneg ? '0 : ((u_i == '0) ? ssa_pkg::HALF_Q16 : ssa_pkg::ONE_Q16);
    side_a.func      = func_i;
    side_a.xneg      = 1'b0;
    side_a.byp       = cfg_i.rect;
    side_a.byp_clamp = cfg_i.rect && !func_i && rect_hit;
    side_a.byp_res   = func_i ? rect_d : rect_v;
  end

  logic va_q, vb_q, vc_q, vd_q, ve_q;
  ssa_pkg::ssa_side_t side_a_q, side_b_q, side_c_q, side_d_q, side_e_q;
  logic [18:0] op_n_a_q;
  logic [37:0] op_w_a_q;
  logic        cap_a_q, uneg_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_a_q <= side_a;
      op_n_a_q <= op_n;
      op_w_a_q <= op_w;
      cap_a_q  <= cap;
      uneg_a_q <= uneg;
    end
  end

  // stage B: x = |c*u| >> FRAC_W, capped at 64.0, as Q.31; sigmoid tail
  logic [56:0] prod_b;
  logic [37:0] y_b, y_b_q;
  logic        xneg_b, tail_b;
  ssa_pkg::ssa_side_t side_b;

  always_comb begin
    prod_b = op_n_a_q * op_w_a_q;
    y_b    = (cap_a_q || (|prod_b[56:38])) ? ssa_pkg::XCAP_Q31 :
             {1'b0, prod_b[37:16], 15'b0};
    xneg_b = (cfg_i.slope_c[47] != uneg_a_q) && (y_b != '0);
    tail_b = !xneg_b && (y_b >= ssa_pkg::TAIL_Q31);
    side_b = side_a_q;
    side_b.xneg = xneg_b;
    if (!side_a_q.byp && tail_b) begin
      side_b.byp       = 1'b1;
      side_b.byp_clamp = 1'b1;
      side_b.byp_res   = side_a_q.func ? '0 : cfg_i.floor_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_b_q <= side_b;
      y_b_q    <= y_b;
    end
  end

  // stage C: estimate n = floor(y / ln2), low by at most one
  logic [54:0] nm_c;
  logic [37:0] y_c_q;
  logic [6:0]  n_c_q;

  assign nm_c = y_b_q[37:16] * ssa_pkg::INV_LN2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_c_q <= side_b_q;
      y_c_q    <= y_b_q;
      n_c_q    <= nm_c[53:47];
    end
  end

  // stage D: n * ln2
  logic [37:0] y_d_q, pn_d_q;
  logic [6:0]  n_d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_d_q <= side_c_q;
      y_d_q    <= y_c_q;
      n_d_q    <= n_c_q;
      pn_d_q   <= n_c_q * ssa_pkg::LN2_Q31;
    end
  end

  // stage E: remainder and one correction step
  logic [37:0] r0_e, r1_e;
  logic        fix_e;
  logic [30:0] r_e_q;
  logic [6:0]  n_e_q;

  always_comb begin
    r0_e  = y_d_q - pn_d_q;
    fix_e = r0_e >= {7'b0, ssa_pkg::LN2_Q31};
    r1_e  = fix_e ? (r0_e - {7'b0, ssa_pkg::LN2_Q31}) : r0_e;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_e_q <= side_d_q;
      r_e_q    <= r1_e[30:0];
      n_e_q    <= n_d_q + 7'(fix_e);
    end
  end

  assign valid_o = ve_q;
  assign side_o  = side_e_q;
  assign r_o     = r_e_q;
  assign n_o     = n_e_q;

endmodule

// ===== sv/ssa_exp.sv =====
// Exponential exp(-y): Taylor series over three stages a term, then divider operands.
module ssa_exp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  ssa_pkg::ssa_side_t   side_i,
  input  logic [30:0]          r_i,
  input  logic [6:0]           n_i,
  output logic                 valid_o,
  output ssa_pkg::ssa_side_t   side_o,
  output logic [62:0]          num_o,
  output logic [32:0]          den_o
);

  localparam int unsigned NST = 3 * ssa_pkg::TERMS;

  logic              vld_q [NST];
  ssa_pkg::ssa_tay_t rec_q [NST];
  logic [31:0]       qe_q  [ssa_pkg::TERMS];

  for (genvar k = 0; k < ssa_pkg::TERMS; k++) begin : g_term
    localparam int unsigned DIV = k + 1;
    localparam logic [32:0] RK  = 33'((64'd1 << 32) / DIV);

    ssa_pkg::ssa_tay_t src, rec1, rec3;
    logic              src_v;
    logic [62:0]       pm;
    logic [64:0]       qm;
    logic [31:0]       rem, q;

    if (k == 0) begin : g_src0
      always_comb begin
        src.side = side_i;
        src.r    = r_i;
        src.n    = n_i;
        src.sum  = 32'h8000_0000;
        src.term = 32'h8000_0000;
        src_v    = in_valid_i;
      end
    end else begin : g_srcn
      assign src   = rec_q[3*k-1];
      assign src_v = vld_q[3*k-1];
    end

    // term * r
    always_comb begin
      pm        = src.term * src.r;
      rec1      = src;
      rec1.term = pm[62:31];
    end

    // quotient estimate by reciprocal
    assign qm = rec_q[3*k].term * RK;

    // correction and series update
    always_comb begin
      rem  = rec_q[3*k+1].term - 32'(qe_q[k] * 32'(DIV));
      q    = qe_q[k] + 32'(rem >= 32'(DIV));
      rec3 = rec_q[3*k+1];
      rec3.term = q;
      rec3.sum  = (DIV % 2 == 1) ? (rec_q[3*k+1].sum - q) : (rec_q[3*k+1].sum + q);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[3*k]   <= 1'b0;
        vld_q[3*k+1] <= 1'b0;
        vld_q[3*k+2] <= 1'b0;
      end else if (en_i) begin
        vld_q[3*k]   <= src_v;
        vld_q[3*k+1] <= vld_q[3*k];
        vld_q[3*k+2] <= vld_q[3*k+1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rec_q[3*k]   <= rec1;
        rec_q[3*k+1] <= rec_q[3*k];
        qe_q[k]      <= qm[63:32];
        rec_q[3*k+2] <= rec3;
      end
    end
  end

  // scale by 2^-n, form 1+e and the first numerator
  ssa_pkg::ssa_tay_t last;
  logic [31:0]       t;
  logic              v_q;
  ssa_pkg::ssa_side_t side_q;
  logic [62:0]       num_q;
  logic [32:0]       den_q;

  always_comb begin
    last = rec_q[NST-1];
    t    = (last.n >= 7'd63) ? '0 : (last.sum >> last.n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= last.side;
      den_q  <= 33'h0_8000_0000 + {1'b0, t};
      num_q  <= (last.side.xneg && !last.side.func) ? 63'h4000_0000_0000_0000 :
                {t, 31'b0};
    end
  end

  assign valid_o = v_q;
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

// ===== sv/ssa_div.sv =====
// Pipelined restoring divider: one quotient bit a stage, 32 stages.
module ssa_div #(
  parameter int unsigned SIDE_W = 52
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  logic [62:0]       num_i,
  input  logic [32:0]       den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       quo_o,
  output logic [32:0]       den_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned NST = ssa_pkg::Q_W;

  logic              vld_q  [NST];
  logic [32:0]       rem_q  [NST];
  logic [31:0]       low_q  [NST];
  logic [31:0]       quo_q  [NST];
  logic [32:0]       den_q  [NST];
  logic [SIDE_W-1:0] side_q [NST];

  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic              src_v;
    logic [32:0]       src_rem, src_den, nrem;
    logic [31:0]       src_low, src_quo;
    logic [SIDE_W-1:0] src_side;
    logic [33:0]       cand, diff;
    logic              ge;

    if (j == 0) begin : g_src0
      assign src_v    = in_valid_i;
      assign src_rem  = {2'b00, num_i[62:32]};
      assign src_low  = num_i[31:0];
      assign src_quo  = '0;
      assign src_den  = den_i;
      assign src_side = side_i;
    end else begin : g_srcn
      assign src_v    = vld_q[j-1];
      assign src_rem  = rem_q[j-1];
      assign src_low  = low_q[j-1];
      assign src_quo  = quo_q[j-1];
      assign src_den  = den_q[j-1];
      assign src_side = side_q[j-1];
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      cand = {src_rem, src_low[31]};
      diff = cand - {1'b0, src_den};
      ge   = cand >= {1'b0, src_den};
      nrem = ge ? diff[32:0] : cand[32:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= nrem;
        low_q[j]  <= {src_low[30:0], 1'b0};
        quo_q[j]  <= {src_quo[30:0], ge};
        den_q[j]  <= src_den;
        side_q[j] <= src_side;
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign quo_o   = quo_q[NST-1];
  assign den_o   = den_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

// ===== sv/ssa_back.sv =====
// Back end: b*q split product, derivative scaling by |c|, final saturation.
module ssa_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  ssa_pkg::ssa_side_t   side_i,
  input  logic [31:0]          q1_i,
  input  logic [31:0]          q2_i,
  input  ssa_pkg::ssa_cfg_t    cfg_i,
  output logic                 valid_o,
  output logic [47:0]          result_o,
  output logic                 clamped_o
);

  logic [47:0] cmag;
  assign cmag = ssa_pkg::mag48(cfg_i.slope_c);

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vo_q;
  ssa_pkg::ssa_side_t side1_q, side2_q, side3_q, side4_q, side5_q, side6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vo_q <= v6_q;
    end
  end

  // b*q over three stages: low half, high half, combine and shift by 31
  logic [31:0] q;
  logic [31:0] q1r_q;
  logic [63:0] plo1_q, plo2_q;
  logic [46:0] phi2_q;
  logic [78:0] bsum;
  logic [46:0] bq3_q, bq4_q, bq5_q, bq6_q;

  assign q    = side_i.func ? q2_i : q1_i;
  assign bsum = {phi2_q, 32'b0} + {15'b0, plo2_q};

  // derivative: (b*g) * |c| in three 16-bit slices of |c|
  logic [94:0] acc4_q, acc5_q, acc6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      q1r_q   <= q;
      plo1_q  <= cfg_i.span_b[31:0] * q;
      side2_q <= side1_q;
      plo2_q  <= plo1_q;
      phi2_q  <= cfg_i.span_b[46:32] * q1r_q;
      side3_q <= side2_q;
      bq3_q   <= bsum[77:31];
      side4_q <= side3_q;
      bq4_q   <= bq3_q;
      acc4_q  <= 95'(bq3_q * cmag[15:0]);
      side5_q <= side4_q;
      bq5_q   <= bq4_q;
      acc5_q  <= acc4_q + (95'(bq4_q * cmag[31:16]) << 16);
      side6_q <= side5_q;
      bq6_q   <= bq5_q;
      acc6_q  <= acc5_q + (95'(bq5_q * cmag[47:32]) << 32);
    end
  end

  // final select and saturation
  logic [78:0] m2;
  logic        big;
  logic [47:0] dval, vval, res;
  logic [47:0] res_q;
  logic        clamp_q;

  always_comb begin
    m2   = acc6_q[94:16];
    big  = |m2[78:47];
    vval = ssa_pkg::sat_add(cfg_i.floor_a, bq6_q);
    if (!cfg_i.slope_c[47]) begin
      dval = big ? ssa_pkg::NEG_MAX : 48'(-{1'b0, m2[46:0]});
    end else begin
      dval = big ? ssa_pkg::POS_MAX : {1'b0, m2[46:0]};
    end
    if (side6_q.byp) begin
      res = side6_q.byp_res;
    end else begin
      res = side6_q.func ? dval : vval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= res;
      clamp_q <= side6_q.byp && side6_q.byp_clamp;
    end
  end

  assign valid_o   = vo_q;
  assign result_o  = res_q;
  assign clamped_o = clamp_q;

endmodule

// ===== sv/scaled_sigmoid_activation.sv =====
// Throughput: one transaction per cycle, set by the fully pipelined exp, two dividers
// (one quotient bit a stage) and split multipliers; a result waiting on the output
// parks in a skid register and the pipeline halts only while that register is full.
// Reset: clears all valid bits, that of the skid register too; configuration returns to
// rectifier off, a = 0, b = 1.0, c = -4.0.
module scaled_sigmoid_activation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [47:0] u
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] result
  output logic        m_axis_tuser    // [0] clamped
);

  localparam int unsigned SIDE1_W = $bits(ssa_pkg::ssa_side_t);
  localparam int unsigned SIDE2_W = SIDE1_W + 32;

  // configuration registers
  ssa_pkg::ssa_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rect    <= 1'b0;
      cfg_q.floor_a <= '0;
      cfg_q.span_b  <= ssa_pkg::SPAN_B_RST;
      cfg_q.slope_c <= ssa_pkg::SLOPE_C_RST;
    end else if (cfg_we_i) begin
      unique case (ssa_pkg::ssa_cfg_idx_e'(cfg_idx_i))
        ssa_pkg::CFG_RECT:    cfg_q.rect    <= cfg_data_i[0];
        ssa_pkg::CFG_FLOOR_A: cfg_q.floor_a <= cfg_data_i;
        ssa_pkg::CFG_SPAN_B:  cfg_q.span_b  <= cfg_data_i[46:0];
        ssa_pkg::CFG_SLOPE_C: cfg_q.slope_c <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance: halted only while the skid register holds a result
  logic skid_v_q;
  logic en;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  logic               fr_v;
  ssa_pkg::ssa_side_t fr_side;
  logic [30:0]        fr_r;
  logic [6:0]         fr_n;

  ssa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (s_axis_tvalid),
    .u_i        (s_axis_tdata),
    .func_i     (s_axis_tuser),
    .cfg_i      (cfg_q),
    .valid_o    (fr_v),
    .side_o     (fr_side),
    .r_o        (fr_r),
    .n_o        (fr_n)
  );

  logic               ex_v;
  ssa_pkg::ssa_side_t ex_side;
  logic [62:0]        ex_num;
  logic [32:0]        ex_den;

  ssa_exp u_exp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (fr_v),
    .side_i     (fr_side),
    .r_i        (fr_r),
    .n_i        (fr_n),
    .valid_o    (ex_v),
    .side_o     (ex_side),
    .num_o      (ex_num),
    .den_o      (ex_den)
  );

  // first division: s = t*2^31/(1+t) or 2^62/(1+t)
  logic               d1_v;
  logic [31:0]        d1_quo;
  logic [32:0]        d1_den;
  logic [SIDE1_W-1:0] d1_side;

  ssa_div #(.SIDE_W(SIDE1_W)) u_div1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (ex_v),
    .num_i      (ex_num),
    .den_i      (ex_den),
    .side_i     (ex_side),
    .valid_o    (d1_v),
    .quo_o      (d1_quo),
    .den_o      (d1_den),
    .side_o     (d1_side)
  );

  // second division: g = s*2^31/(1+t)
  logic               d2_v;
  logic [31:0]        d2_quo;
  logic [32:0]        d2_den;
  logic [SIDE2_W-1:0] d2_side;
  ssa_pkg::ssa_side_t bk_side;

  ssa_div #(.SIDE_W(SIDE2_W)) u_div2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (d1_v),
    .num_i      ({d1_quo, 31'b0}),
    .den_i      (d1_den),
    .side_i     ({d1_side, d1_quo}),
    .valid_o    (d2_v),
    .quo_o      (d2_quo),
    .den_o      (d2_den),
    .side_o     (d2_side)
  );

  assign bk_side = ssa_pkg::ssa_side_t'(d2_side[SIDE2_W-1:32]);

  logic        bk_v;
  logic [47:0] bk_res;
  logic        bk_clamp;

  ssa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en && (d2_den != '0 || 1'b1)),
    .in_valid_i (d2_v),
    .side_i     (bk_side),
    .q1_i       (d2_side[31:0]),
    .q2_i       (d2_quo),
    .cfg_i      (cfg_q),
    .valid_o    (bk_v),
    .result_o   (bk_res),
    .clamped_o  (bk_clamp)
  );

  // output skid register
  logic [47:0] skid_res_q;
  logic        skid_clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) skid_v_q <= 1'b0;
    end else if (bk_v && !m_axis_tready) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && bk_v && !m_axis_tready) begin
      skid_res_q   <= bk_res;
      skid_clamp_q <= bk_clamp;
    end
  end

  assign m_axis_tvalid = skid_v_q || bk_v;
  assign m_axis_tdata  = skid_v_q ? skid_res_q : bk_res;
  assign m_axis_tuser  = skid_v_q ? skid_clamp_q : bk_clamp;

endmodule

// ===== sv/ssa_checker.sv =====
// Port-level checker for the scaled sigmoid activation, bound to the top level.
module ssa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  // input back-pressure only while a parked result is on offer
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // taking the parked result releases the input side
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && m_axis_tready |=> s_axis_tready)
    else $error("input still stalled after parked result was taken");

endmodule

bind scaled_sigmoid_activation ssa_checker u_ssa_checker (.*);

// ===== test/tb_scaled_sigmoid_activation.sv =====
// Self-checking testbench for the scaled sigmoid activation: directed and random arguments.
module tb_scaled_sigmoid_activation;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 130;

  typedef struct packed {
    logic [47:0] res;
    logic        clamped;
  } act_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [47:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  // local copy of the configuration registers
  logic        mdl_rect;
  logic [47:0] mdl_a;
  logic [46:0] mdl_b;
  logic [47:0] mdl_c;

  act_out_t    pending_q[$];
  int unsigned err_count;
  int unsigned cycle_count;
  bit          no_idle;

  scaled_sigmoid_activation u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  // (x*y) >> sh, all ones when the shifted product overflows 64 bits
  function automatic logic [63:0] prod_shift(input logic [63:0] x, input logic [63:0] y,
                                             input int sh);
    logic [127:0] p;
    p = 128'(x) * 128'(y);
    if ((p >> (64 + sh)) != 0) return '1;
    return 64'(p >> sh);
  endfunction

  // signed word from sign and magnitude, saturated
  function automatic logic [47:0] to_word(input logic neg, input logic [63:0] mag);
    logic [63:0] half;
    half = 64'd1 << 47;
    if (neg && mag != 0) begin
      if (mag > half) mag = half;
      return 48'(-mag);
    end
    return (mag > half - 1) ? 48'(half - 1) : 48'(mag);
  endfunction

  function automatic logic [47:0] offset_by_a(input logic aneg, input logic [63:0] amag,
                                              input logic [63:0] p);
    if (!aneg) return to_word(1'b0, amag + p);
    if (p >= amag) return to_word(1'b0, p - amag);
    return to_word(1'b1, amag - p);
  endfunction

  // exp(-y), y and result in Q.31
  function automatic logic [63:0] exp_decay(input logic [63:0] y);
    logic [63:0] n, r, sum, term;
    n = y / 64'd1488522236;
    r = y - n * 64'd1488522236;
    sum = 64'd1 << 31;
    term = 64'd1 << 31;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * r) >> 31) / 64'(k);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return (n >= 63) ? 64'd0 : (sum >> n);
  endfunction

  function automatic act_out_t predict_activation(input logic [47:0] u, input logic fn);
    act_out_t    o;
    logic        uneg, aneg, cneg, xneg;
    logic [63:0] umag, amag, cmag, x, t, d, s, g, m1, m2, p;
    uneg = u[47];
    umag = 64'(uneg ? 48'(-u) : u);
    aneg = mdl_a[47];
    amag = 64'(aneg ? 48'(-mdl_a) : mdl_a);
    cneg = mdl_c[47];
    cmag = 64'(cneg ? 48'(-mdl_c) : mdl_c);
    o.clamped = 1'b0;
    if (mdl_rect) begin
      if (fn) begin
        if (uneg) o.res = '0;
        else if (umag == 0) o.res = 48'd1 << 15;
        else o.res = 48'd1 << 16;
      end else begin
        p = 0;
        if (!uneg) begin
          p = umag;
          if (umag >= (64'd1000000 << 16)) begin
            p = 64'd1000000 << 16;
            o.clamped = 1'b1;
          end
        end
        o.res = offset_by_a(aneg, amag, p);
      end
    end else begin
      x = prod_shift(cmag, umag, 16);
      if (x > (64'd64 << 16)) x = 64'd64 << 16;
      x = x << 15;
      xneg = (cneg != uneg) && x != 0;
      if (!xneg && x >= 64'd118674332048) begin
        o.clamped = 1'b1;
        o.res = fn ? 48'd0 : to_word(aneg, amag);
      end else begin
        t = exp_decay(x);
        d = (64'd1 << 31) + t;
        if (fn) begin
          g = (((t << 31) / d) << 31) / d;
          m1 = prod_shift(64'(mdl_b), g, 31);
          m2 = prod_shift(m1, cmag, 16);
          o.res = to_word(!cneg, m2);
        end else begin
          s = xneg ? ((64'd1 << 62) / d) : ((t << 31) / d);
          o.res = offset_by_a(aneg, amag, prod_shift(64'(mdl_b), s, 31));
        end
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_arg(input logic [47:0] u, input logic fn);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= u;
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(predict_activation(u, fn));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input ssa_pkg::ssa_cfg_idx_e idx, input logic [47:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      ssa_pkg::CFG_RECT:    mdl_rect = val[0];
      ssa_pkg::CFG_FLOOR_A: mdl_a = val;
      ssa_pkg::CFG_SPAN_B:  mdl_b = val[46:0];
      default:              mdl_c = val;
    endcase
  endtask

  task automatic set_config(input logic rect, input logic [47:0] a, input logic [46:0] b,
                            input logic [47:0] c);
    wait_idle();
    write_reg(ssa_pkg::CFG_RECT, 48'(rect));
    write_reg(ssa_pkg::CFG_FLOOR_A, a);
    write_reg(ssa_pkg::CFG_SPAN_B, 48'(b));
    write_reg(ssa_pkg::CFG_SLOPE_C, c);
  endtask

  // ---------------------------------------------------------------- result side

  int stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    act_out_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result %h clamped %b", m_axis_tdata, m_axis_tuser);
        end else begin
          want = pending_q.pop_front();
          if (want.res !== m_axis_tdata || want.clamped !== m_axis_tuser) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: exp %h/%b got %h/%b", want.res, want.clamped,
                       m_axis_tdata, m_axis_tuser);
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_scaled_sigmoid_activation: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  function automatic logic [47:0] rand_word();
    return {16'($urandom), $urandom};
  endfunction

  // mostly arguments where the exponential is live, some full range
  function automatic logic [47:0] rand_arg();
    logic [47:0] v;
    case ($urandom_range(0, 7))
      0, 1:    v = rand_word();
      2:       v = 48'((64'd1000000 << 16) + 48'($signed($urandom_range(0, 64)) - 32));
      3:       v = 48'($urandom_range(0, 3)) - 48'd1;
      default: v = 48'($urandom_range(0, 1 << 22)) >> $urandom_range(0, 8);
    endcase
    if ($urandom_range(0, 1) && v[47] == 1'b0) v = -v;
    return v;
  endfunction

  task automatic test_reset_defaults();
    mdl_rect = 1'b0;
    mdl_a = '0;
    mdl_b = ssa_pkg::SPAN_B_RST;
    mdl_c = ssa_pkg::SLOPE_C_RST;
    for (int f = 0; f < 2; f++) begin
      send_arg(48'd0, f[0]);
      send_arg(48'd65536, f[0]);
      send_arg(-48'd65536, f[0]);
    end
  endtask

  task automatic test_sigmoid_edges();
    set_config(1'b0, 48'd0, 47'd65536, 48'd65536);
    for (int f = 0; f < 2; f++) begin
      // tail boundary near ln 1e24 = 55.26
      send_arg(48'd3621530, f[0]);
      send_arg(48'd3621600, f[0]);
      send_arg(48'h7FFF_FFFF_FFFF, f[0]);
      send_arg(48'h8000_0000_0000, f[0]);
      send_arg(48'd1, f[0]);
      send_arg(-48'd1, f[0]);
    end
    // widest span and extreme floors saturate
    set_config(1'b0, 48'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    send_arg(-48'd1, 1'b0);
    send_arg(48'd1, 1'b1);
    set_config(1'b0, 48'h8000_0000_0000, 47'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    send_arg(48'd0, 1'b0);
    send_arg(48'd0, 1'b1);
    send_arg(-48'd5, 1'b0);
  endtask

  task automatic test_rectifier_edges();
    set_config(1'b1, 48'h7FFF_FFFF_0000, 47'd0, ssa_pkg::SLOPE_C_RST);
    for (int f = 0; f < 2; f++) begin
      send_arg(48'd0, f[0]);
      send_arg(48'(64'd1000000 << 16), f[0]);
      send_arg(48'((64'd1000000 << 16) - 1), f[0]);
      send_arg(48'h7FFF_FFFF_FFFF, f[0]);
      send_arg(48'h8000_0000_0000, f[0]);
      send_arg(48'd1, f[0]);
    end
    set_config(1'b1, 48'h8000_0000_0000, 47'd0, ssa_pkg::SLOPE_C_RST);
    send_arg(48'd77, 1'b0);
  endtask

  task automatic run_random(input logic rect, input logic [47:0] a, input logic [46:0] b,
                            input logic [47:0] c, input int count);
    set_config(rect, a, b, c);
    for (int i = 0; i < count; i++) begin
      // busy stretch with no idling on either side
      no_idle = (i >= count / 2) && (i < count / 2 + 25);
      send_arg(rand_arg(), 1'($urandom));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_settings();
    run_random(1'b0, 48'd0, 47'd65536, ssa_pkg::SLOPE_C_RST, 160);
    run_random(1'b0, 48'h8000_0000_0000, 47'h7FFF_FFFF_FFFF, 48'd262144, 150);
    run_random(1'b0, 48'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 150);
    run_random(1'b0, rand_word(), 47'(rand_word()), 48'd0, 100);
    run_random(1'b1, 48'd0, 47'd65536, ssa_pkg::SLOPE_C_RST, 150);
    run_random(1'b1, 48'h8000_0000_0000, 47'd0, rand_word(), 120);
    for (int k = 0; k < 4; k++)
      run_random(1'b0, rand_word(), 47'($urandom) << $urandom_range(0, 15),
                 48'($signed($urandom_range(0, 1 << 20)) - (1 << 19)), 100);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = ssa_pkg::CFG_RECT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    err_count     = 0;
    cycle_count   = 0;
    no_idle       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_sigmoid_edges();
    test_rectifier_edges();
    test_random_settings();
    wait_idle();

    if (err_count == 0) begin
      $display("tb_scaled_sigmoid_activation: clean");
    end else begin
      $display("tb_scaled_sigmoid_activation: errors");
    end
    $finish;
  end

endmodule
